// ===== rtl/core/crc_frame_reassembler_core_macros.svh =====
// Assertion macros for the frame reassembler
`ifndef CRC_FRAME_REASSEMBLER_CORE_MACROS_SVH
`define CRC_FRAME_REASSEMBLER_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CFR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error(msg);
`define CFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error(msg);
`else
`define CFR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define CFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/core/cfr_pkg.sv =====
package cfr_pkg;
	localparam int unsigned MSG_MAX = 4096;
	localparam int unsigned AW = $clog2(MSG_MAX);
	localparam int unsigned LW = AW + 1;
	localparam int unsigned HDR_LEN = 8;
	localparam logic [16:0] COUNT_MAX = 17'h1FFFF;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	localparam logic [1:0] REG_MAGIC0 = 2'd0;
	localparam logic [1:0] REG_MAGIC1 = 2'd1;
	localparam logic [1:0] REG_VERSION = 2'd2;

	localparam logic [3:0] ST_PARTIAL = 4'd0;
	localparam logic [3:0] ST_COMPLETE = 4'd1;
	localparam logic [3:0] ST_SHORT = 4'd2;
	localparam logic [3:0] ST_MAGIC = 4'd3;
	localparam logic [3:0] ST_VERSION = 4'd4;
	localparam logic [3:0] ST_LENGTH = 4'd5;
	localparam logic [3:0] ST_CRC = 4'd6;
	localparam logic [3:0] ST_BAD_SEQ = 4'd7;
	localparam logic [3:0] ST_ORDER = 4'd8;
	localparam logic [3:0] ST_OVERFLOW = 4'd9;

	typedef enum logic [2:0] {
		S_IDLE, S_CHECK, S_COPY, S_COPY_LAST, S_RDWAIT, S_OUT
	} state_t;

	typedef struct packed {
		logic [7:0] mtype;
		logic [LW-1:0] mlen;
		logic [3:0] status;
		logic kind;
		logic [7:0] rdata;
	} result_t;

	// buffer control (staging writes, copy, message reads) between sequencer and stores
	typedef struct packed {
		logic stg_we;
		logic [AW-1:0] stg_waddr;
		logic [7:0] stg_wdata;
		logic stg_re;
		logic [AW-1:0] stg_raddr;
		logic msg_we;
		logic [AW-1:0] msg_waddr;
		logic msg_re;
		logic [AW-1:0] msg_raddr;
	} mem_ctl_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) c = {c[14:0], 1'b0} ^ CRC_POLY;
			else c = {c[14:0], 1'b0};
		end
		return c;
	endfunction
endpackage

// ===== rtl/core/cfr_if.sv =====
interface cfr_in_if;
	logic valid;
	logic ready;
	logic req_type;
	logic [7:0] data_byte;
	logic last_byte;
	logic [11:0] read_index;
	modport source(output valid, req_type, data_byte, last_byte, read_index, input ready);
	modport sink(input valid, req_type, data_byte, last_byte, read_index, output ready);
endinterface

interface cfr_out_if;
	logic valid;
	logic ready;
	logic result_kind;
	logic [3:0] frame_status;
	logic [7:0] message_type;
	logic [12:0] message_length;
	logic [7:0] read_data;
	modport source(output valid, result_kind, frame_status, message_type, message_length,
		read_data, input ready);
	modport sink(input valid, result_kind, frame_status, message_type, message_length,
		read_data, output ready);
endinterface

interface cfr_cfg_if;
	logic valid;
	logic ready;
	logic [1:0] index;
	logic [7:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/core/crc_frame_reassembler_core.sv =====
// Frame reassembler with CRC-16 check. Frame bytes enter one per item; a
// byte without the last flag gives no result. The item with the last flag
// runs a check state and, for a good in-sequence frame, copies the payload
// from the staging buffer into the message buffer at one byte per cycle
// before the status result is offered. A read item waits in S_RDWAIT for
// the registered message buffer read. Both buffers are single-port-per-side
// synchronous RAMs of MSG_MAX bytes; message bytes never written read back
// as undefined. A new item is taken only once the previous result has been
// handed on. Config writes are accepted at any time and are meant to happen
// only while idle.
`include "crc_frame_reassembler_core_macros.svh"
module crc_frame_reassembler_core (
	input logic clk,
	input logic arst_n,
	cfr_in_if.sink in_ch,
	cfr_out_if.source out_ch,
	cfr_cfg_if.sink cfg
);
	import cfr_pkg::*;

	state_t state_q, state_d;

	// configuration
	logic [7:0] magic0_q, magic1_q, version_q;

	// frame state
	logic [16:0] byte_count_q;
	logic [7:0] hdr_q [HDR_LEN];
	logic [15:0] crc_q;
	logic [15:0] pair_q;

	// reassembly state
	logic [LW-1:0] asm_count_q;
	logic [7:0] next_seq_q, cur_type_q;
	logic assembling_q;

	// copy engine
	logic [AW-1:0] cp_idx_q;
	logic [LW-1:0] cp_len_q;
	logic [AW-1:0] cp_base_q;

	result_t res_q;
	mem_ctl_t mctl;
	logic [7:0] stg_rdata, msg_rdata;

	cfr_stores u_stores (
		.clk(clk), .ctl(mctl), .stg_rdata(stg_rdata), .msg_rdata(msg_rdata)
	);

	logic in_fire, out_fire;
	assign in_fire = in_ch.valid && in_ch.ready;
	assign out_fire = out_ch.valid && out_ch.ready;
	assign cfg.ready = 1'b1;

	// frame byte position decode
	logic [15:0] hdr_len_w;
	logic [17:0] exp_count;
	logic [3:0] chk_status;
	logic chk_clear, chk_copy;
	logic [16:0] sum_len;
	logic [16:0] stg_pos;

	assign hdr_len_w = {hdr_q[6], hdr_q[7]};
	assign exp_count = {2'b00, hdr_len_w} + 18'd10;
	// full header length, so a long payload cannot wrap past the overflow check
	assign sum_len = {{(17 - LW){1'b0}}, asm_count_q} + {1'b0, hdr_len_w};
	assign stg_pos = byte_count_q - 17'(HDR_LEN);

	// combinational frame-end check (all compares on registered header)
	always_comb begin
		chk_status = ST_PARTIAL;
		chk_clear = 1'b0;
		chk_copy = 1'b0;
		if (byte_count_q < 17'd10) chk_status = ST_SHORT;
		else if (hdr_q[0] != magic0_q || hdr_q[1] != magic1_q) chk_status = ST_MAGIC;
		else if (hdr_q[2] != version_q) chk_status = ST_VERSION;
		else if ({1'b0, byte_count_q} != exp_count) chk_status = ST_LENGTH;
		else if (crc_q != pair_q) chk_status = ST_CRC;
		else if (hdr_q[5] == 8'd0 || hdr_q[4] >= hdr_q[5]) begin
			chk_status = ST_BAD_SEQ;
			chk_clear = 1'b1;
		end else if (hdr_q[4] != 8'd0 && (!assembling_q || cur_type_q != hdr_q[3] ||
				hdr_q[4] != next_seq_q)) begin
			chk_status = ST_ORDER;
			chk_clear = 1'b1;
		end else if ((hdr_q[4] == 8'd0 ? {1'b0, hdr_len_w} : sum_len) >
				17'(MSG_MAX)) begin
			chk_status = ST_OVERFLOW;
			chk_clear = 1'b1;
		end else begin
			chk_copy = 1'b1;
			chk_status = (9'(hdr_q[4]) + 9'd1 == 9'(hdr_q[5])) ? ST_COMPLETE : ST_PARTIAL;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					if (in_ch.req_type) state_d = S_RDWAIT;
					else if (in_ch.last_byte) state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (chk_copy && hdr_len_w != 16'd0) state_d = S_COPY;
				else state_d = S_OUT;
			end
			S_COPY: if (LW'(cp_idx_q) + LW'(1) == cp_len_q) state_d = S_COPY_LAST;
			S_COPY_LAST: state_d = S_OUT;
			S_RDWAIT: state_d = S_OUT;
			S_OUT: if (out_fire) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs and memory control
	always_comb begin
		in_ch.ready = (state_q == S_IDLE);
		out_ch.valid = (state_q == S_OUT);
		out_ch.result_kind = res_q.kind;
		out_ch.frame_status = res_q.status;
		out_ch.message_type = res_q.mtype;
		out_ch.message_length = 13'(res_q.mlen);
		out_ch.read_data = (state_q == S_OUT && res_q.kind) ? msg_rdata : 8'd0;
		mctl = '0;
		mctl.stg_we = in_fire && !in_ch.req_type && byte_count_q >= 17'(HDR_LEN) &&
			stg_pos < 17'(MSG_MAX);
		mctl.stg_waddr = stg_pos[AW-1:0];
		mctl.stg_wdata = in_ch.data_byte;
		mctl.stg_re = (state_q == S_COPY) || (state_q == S_CHECK);
		mctl.stg_raddr = (state_q == S_CHECK) ? '0 : AW'(cp_idx_q + AW'(1));
		mctl.msg_we = (state_q == S_COPY);
		mctl.msg_waddr = cp_base_q + cp_idx_q;
		mctl.msg_re = in_fire && in_ch.req_type;
		mctl.msg_raddr = in_ch.read_index[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			magic0_q <= '0;
			magic1_q <= '0;
			version_q <= '0;
			byte_count_q <= '0;
			for (int i = 0; i < HDR_LEN; i++) hdr_q[i] <= '0;
			crc_q <= CRC_INIT;
			pair_q <= '0;
			asm_count_q <= '0;
			next_seq_q <= '0;
			cur_type_q <= '0;
			assembling_q <= 1'b0;
			cp_idx_q <= '0;
			cp_len_q <= '0;
			cp_base_q <= '0;
			res_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				case (cfg.index)
					REG_MAGIC0: magic0_q <= cfg.data;
					REG_MAGIC1: magic1_q <= cfg.data;
					REG_VERSION: version_q <= cfg.data;
					default: ;
				endcase
			end
			if (in_fire) begin
				if (in_ch.req_type) begin
					res_q <= '{mtype: 8'd0, mlen: '0, status: ST_PARTIAL, kind: 1'b1,
						rdata: 8'd0};
				end else begin
					if (byte_count_q < 17'(HDR_LEN)) hdr_q[byte_count_q[2:0]] <= in_ch.data_byte;
					if (byte_count_q >= 17'd2) crc_q <= crc_byte(crc_q, pair_q[15:8]);
					pair_q <= {pair_q[7:0], in_ch.data_byte};
					if (byte_count_q != COUNT_MAX) byte_count_q <= byte_count_q + 17'd1;
				end
			end
			if (state_q == S_CHECK) begin
				byte_count_q <= '0;
				crc_q <= CRC_INIT;
				pair_q <= '0;
				cp_idx_q <= '0;
				cp_len_q <= hdr_len_w[LW-1:0];
				res_q.kind <= 1'b0;
				res_q.status <= chk_status;
				res_q.mtype <= '0;
				res_q.mlen <= '0;
				if (chk_clear) begin
					cur_type_q <= '0;
					next_seq_q <= '0;
					asm_count_q <= '0;
					assembling_q <= 1'b0;
				end
				if (chk_copy) begin
					if (hdr_q[4] == 8'd0) begin
						cur_type_q <= hdr_q[3];
						next_seq_q <= 8'd1;
						cp_base_q <= '0;
						asm_count_q <= hdr_len_w[LW-1:0];
						res_q.mlen <= hdr_len_w[LW-1:0];
					end else begin
						next_seq_q <= next_seq_q + 8'd1;
						cp_base_q <= asm_count_q[AW-1:0];
						asm_count_q <= sum_len[LW-1:0];
						res_q.mlen <= sum_len[LW-1:0];
					end
					assembling_q <= (chk_status != ST_COMPLETE);
					if (chk_status == ST_COMPLETE) begin
						res_q.mtype <= (hdr_q[4] == 8'd0) ? hdr_q[3] : cur_type_q;
					end
				end
			end
			if (state_q == S_COPY) cp_idx_q <= cp_idx_q + AW'(1);
		end
	end

	`CFR_ASSERT_IMPL(a_no_in_busy, clk, arst_n, state_q != S_IDLE, !in_ch.ready, "input taken while busy")
	`CFR_ASSERT_IMPL(a_frame_reset, clk, arst_n, state_q == S_OUT && !res_q.kind, byte_count_q == '0, "frame state not cleared")
	`CFR_ASSERT_NEXT(a_check_exit, clk, arst_n, state_q == S_CHECK, state_q == S_COPY || state_q == S_OUT, "check did not advance")
	`CFR_ASSERT_IMPL(a_count_max, clk, arst_n, 1'b1, asm_count_q <= LW'(MSG_MAX), "assembled count beyond buffer")
endmodule

// ===== rtl/core/cfr_stores.sv =====
// staging and message buffers with registered reads
module cfr_stores (
	input logic clk,
	input cfr_pkg::mem_ctl_t ctl,
	output logic [7:0] stg_rdata,
	output logic [7:0] msg_rdata
);
	import cfr_pkg::*;

	logic [7:0] stg_mem [MSG_MAX];
	logic [7:0] msg_mem [MSG_MAX];

	always_ff @(posedge clk) begin
		if (ctl.stg_we) stg_mem[ctl.stg_waddr] <= ctl.stg_wdata;
		if (ctl.stg_re) stg_rdata <= stg_mem[ctl.stg_raddr];
	end

	// copy write data comes straight from staging read data
	always_ff @(posedge clk) begin
		if (ctl.msg_we) msg_mem[ctl.msg_waddr] <= stg_rdata;
		if (ctl.msg_re) msg_rdata <= msg_mem[ctl.msg_raddr];
	end
endmodule
